// File: rtl/gap_pkg.sv
package gap_pkg;

    localparam int GRID_W = 8;
    localparam int GRID_H = 8;
    localparam int NCELLS = GRID_W * GRID_H;
    localparam int IDX_W  = $clog2(NCELLS);
    localparam int COST_W = 7;
    localparam int F_W    = 9;
    localparam int CX_OFF = (GRID_W - 1) / 2;
    localparam int CY_OFF = (GRID_H - 1) / 2;

    typedef enum logic [1:0] {
        REQ_SET_WALK = 2'd0,
        REQ_OCCUPY   = 2'd1,
        REQ_RELEASE  = 2'd2,
        REQ_FIND     = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        DIR_XP = 2'd0,
        DIR_XN = 2'd1,
        DIR_YP = 2'd2,
        DIR_YN = 2'd3
    } t_dir;

    typedef struct packed {
        logic [1:0]        req_type;
        logic signed [7:0] cell_x;
        logic signed [7:0] cell_y;
        logic              walk_value;
        logic signed [7:0] goal_x;
        logic signed [7:0] goal_y;
    } t_in;

    typedef struct packed {
        logic signed [7:0] path_x;
        logic signed [7:0] path_y;
        logic              found;
        logic              last;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CLEAR,
        ST_SCAN,
        ST_PICK,
        ST_NRD,
        ST_NBR,
        ST_TRACE,
        ST_TSTEP,
        ST_ELOAD,
        ST_EMIT,
        ST_FAIL
    } t_state;

endpackage

// File: rtl/grid_astar_pathfinder.sv
// channel   ports                       transfer
// request   i_start, o_busy, i_req      start high while busy low
// result    o_valid, o_res              one cycle per strobe, no back pressure
//
// set, occupy and release: a check state, the result strobed in the next cycle
// path search: check and clear, then per expansion a scan of every cell through the
// shared f compare unit, a pick state and a read and an update state per neighbor
// a found path is traced back from the goal, then loaded and emitted one cell per result
// reset sets every cell walkable and none occupied
// results cannot be stalled; busy drops in the cycle carrying the last result
module grid_astar_pathfinder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  gap_pkg::t_in  i_req,
    output logic          o_busy,
    output logic          o_valid,
    output gap_pkg::t_out o_res
);

    localparam int IW = gap_pkg::IDX_W;
    localparam int CW = gap_pkg::COST_W;
    localparam int FW = gap_pkg::F_W;
    localparam int N  = gap_pkg::NCELLS;
    localparam int XW = $clog2(gap_pkg::GRID_W) + 1;
    localparam int YW = $clog2(gap_pkg::GRID_H) + 1;

    gap_pkg::t_state r_state, n_state;
    gap_pkg::t_in    r_req;

    logic [N-1:0] r_walk, r_occ, r_open, r_closed;
    logic [CW-1:0] r_cost [N];
    logic [1:0]    r_par  [N];
    logic [IW-1:0] r_path [N];
    logic [CW-1:0] r_cost_a, r_cost_b;
    logic [1:0]    r_par_q;
    logic [IW-1:0] r_path_q;

    logic [IW:0]   r_cnt;
    logic [IW-1:0] r_best, r_start, r_goal, r_cur;
    logic          r_have;
    logic [FW-1:0] r_bestf;
    logic [1:0]    r_dir;
    logic [IW:0]   r_n;
    logic          r_valid;
    gap_pkg::t_out r_res;

    function automatic logic [8:0] grid_coord(input logic signed [7:0] c, input int off);
        grid_coord = 9'(signed'(c)) + 9'(off);
    endfunction

    logic [8:0] s_gx, s_gy, e_gx, e_gy;
    logic s_in, e_in;
    logic [IW-1:0] s_idx, e_idx;
    always_comb begin
        s_gx = grid_coord(r_req.cell_x, gap_pkg::CX_OFF);
        s_gy = grid_coord(r_req.cell_y, gap_pkg::CY_OFF);
        e_gx = grid_coord(r_req.goal_x, gap_pkg::CX_OFF);
        e_gy = grid_coord(r_req.goal_y, gap_pkg::CY_OFF);
        s_in = !s_gx[8] && !s_gy[8] && s_gx < 9'(gap_pkg::GRID_W) && s_gy < 9'(gap_pkg::GRID_H);
        e_in = !e_gx[8] && !e_gy[8] && e_gx < 9'(gap_pkg::GRID_W) && e_gy < 9'(gap_pkg::GRID_H);
        s_idx = IW'(s_gy * 9'(gap_pkg::GRID_W) + s_gx);
        e_idx = IW'(e_gy * 9'(gap_pkg::GRID_W) + e_gx);
    end

    // shared f unit on the scanned cell, its cost read in the cycle before
    logic [IW-1:0] scan_i;
    logic [IW-1:0] cost_ra;
    logic [XW-1:0] sx_c, gx_c;
    logic [YW-1:0] sy_c, gy_c;
    logic [FW-1:0] f_val;
    logic          f_take;
    always_comb begin
        scan_i = IW'(r_cnt - (IW+1)'(1));
        cost_ra = (r_state == gap_pkg::ST_SCAN) ? r_cnt[IW-1:0] : r_best;
        sx_c = XW'(scan_i % IW'(gap_pkg::GRID_W));
        sy_c = YW'(scan_i / IW'(gap_pkg::GRID_W));
        gx_c = XW'(r_goal % IW'(gap_pkg::GRID_W));
        gy_c = YW'(r_goal / IW'(gap_pkg::GRID_W));
        f_val = FW'(r_cost_a)
              + FW'((sx_c > gx_c) ? sx_c - gx_c : gx_c - sx_c)
              + FW'((sy_c > gy_c) ? sy_c - gy_c : gy_c - sy_c);
        f_take = (r_cnt != '0) && r_open[scan_i] && !r_closed[scan_i]
              && (!r_have || f_val < r_bestf);
    end

    // neighbor of best in direction r_dir
    logic [XW-1:0] bx;
    logic [YW-1:0] by;
    logic          nb_ok;
    logic [IW-1:0] nb_i;
    logic [CW-1:0] nb_g;
    always_comb begin
        bx = XW'(r_best % IW'(gap_pkg::GRID_W));
        by = YW'(r_best / IW'(gap_pkg::GRID_W));
        nb_ok = 1'b0;
        nb_i  = r_best;
        unique case (gap_pkg::t_dir'(r_dir))
            gap_pkg::DIR_XP: begin
                nb_ok = bx < XW'(gap_pkg::GRID_W - 1);
                nb_i  = r_best + IW'(1);
            end
            gap_pkg::DIR_XN: begin
                nb_ok = bx != '0;
                nb_i  = r_best - IW'(1);
            end
            gap_pkg::DIR_YP: begin
                nb_ok = by < YW'(gap_pkg::GRID_H - 1);
                nb_i  = r_best + IW'(gap_pkg::GRID_W);
            end
            gap_pkg::DIR_YN: begin
                nb_ok = by != '0;
                nb_i  = r_best - IW'(gap_pkg::GRID_W);
            end
        endcase
        nb_g = r_cost_a + CW'(1);
        nb_ok = nb_ok && r_walk[nb_i] && (!r_occ[nb_i] || nb_i == r_goal) && !r_closed[nb_i]
             && (!r_open[nb_i] || nb_g < r_cost_b);
    end

    // parent step for trace back
    logic [IW-1:0] par_i;
    always_comb begin
        unique case (gap_pkg::t_dir'(r_par_q))
            gap_pkg::DIR_XP: par_i = r_cur - IW'(1);
            gap_pkg::DIR_XN: par_i = r_cur + IW'(1);
            gap_pkg::DIR_YP: par_i = r_cur - IW'(gap_pkg::GRID_W);
            gap_pkg::DIR_YN: par_i = r_cur + IW'(gap_pkg::GRID_W);
        endcase
    end

    logic [IW-1:0] em_c, path_ra;
    assign em_c = r_path_q;
    always_comb begin
        if (r_state == gap_pkg::ST_EMIT) path_ra = IW'(r_n - (IW+1)'(2));
        else                             path_ra = IW'(r_n - (IW+1)'(1));
    end

    always_ff @(posedge i_clk) begin
        if (r_state == gap_pkg::ST_CLEAR) begin
            r_cost[r_start] <= '0;
        end else if (r_state == gap_pkg::ST_NBR && nb_ok) begin
            r_cost[nb_i] <= nb_g;
            r_par[nb_i]  <= r_dir;
        end
        if (r_state == gap_pkg::ST_TRACE) r_path[IW'(r_n)] <= r_cur;
        r_cost_a <= r_cost[cost_ra];
        r_cost_b <= r_cost[nb_i];
        r_par_q  <= r_par[r_cur];
        r_path_q <= r_path[path_ra];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gap_pkg::ST_IDLE:  if (i_start) n_state = gap_pkg::ST_CHECK;
            gap_pkg::ST_CHECK: begin
                if (r_req.req_type != gap_pkg::REQ_FIND) n_state = gap_pkg::ST_IDLE;
                else if (!s_in || !e_in || !r_walk[s_idx] || !r_walk[e_idx])
                    n_state = gap_pkg::ST_FAIL;
                else n_state = gap_pkg::ST_CLEAR;
            end
            gap_pkg::ST_CLEAR: n_state = gap_pkg::ST_SCAN;
            gap_pkg::ST_SCAN:  if (r_cnt == (IW+1)'(N)) n_state = gap_pkg::ST_PICK;
            gap_pkg::ST_PICK: begin
                if (!r_have) n_state = gap_pkg::ST_FAIL;
                else if (r_best == r_goal) n_state = gap_pkg::ST_TRACE;
                else n_state = gap_pkg::ST_NRD;
            end
            gap_pkg::ST_NRD:   n_state = gap_pkg::ST_NBR;
            gap_pkg::ST_NBR: begin
                if (r_dir == gap_pkg::DIR_YN) n_state = gap_pkg::ST_SCAN;
                else n_state = gap_pkg::ST_NRD;
            end
            gap_pkg::ST_TRACE: begin
                if (r_cur == r_start) n_state = gap_pkg::ST_ELOAD;
                else n_state = gap_pkg::ST_TSTEP;
            end
            gap_pkg::ST_TSTEP: n_state = gap_pkg::ST_TRACE;
            gap_pkg::ST_ELOAD: n_state = gap_pkg::ST_EMIT;
            gap_pkg::ST_EMIT:  if (r_n == (IW+1)'(1)) n_state = gap_pkg::ST_IDLE;
            gap_pkg::ST_FAIL:  n_state = gap_pkg::ST_IDLE;
            default:           n_state = gap_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= gap_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk  <= '1;
            r_occ   <= '0;
            r_open  <= '0;
            r_closed <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                gap_pkg::ST_IDLE: if (i_start) r_req <= i_req;
                gap_pkg::ST_CHECK: begin
                    if (r_req.req_type != gap_pkg::REQ_FIND) begin
                        if (s_in) begin
                            if (r_req.req_type == gap_pkg::REQ_SET_WALK)
                                r_walk[s_idx] <= r_req.walk_value;
                            else if (r_req.req_type == gap_pkg::REQ_OCCUPY)
                                r_occ[s_idx] <= 1'b1;
                            else
                                r_occ[s_idx] <= 1'b0;
                        end
                        r_valid <= 1'b1;
                        r_res   <= '{r_req.cell_x, r_req.cell_y, 1'b0, 1'b1};
                    end
                    r_start <= s_idx;
                    r_goal  <= e_idx;
                end
                gap_pkg::ST_CLEAR: begin
                    r_open   <= N'(1) << r_start;
                    r_closed <= '0;
                    r_cnt  <= '0;
                    r_have <= 1'b0;
                end
                gap_pkg::ST_SCAN: begin
                    if (f_take) begin
                        r_have  <= 1'b1;
                        r_bestf <= f_val;
                        r_best  <= scan_i;
                    end
                    r_cnt <= r_cnt + (IW+1)'(1);
                end
                gap_pkg::ST_PICK: begin
                    if (r_have) begin
                        r_open[r_best]   <= 1'b0;
                        r_closed[r_best] <= 1'b1;
                    end
                    r_dir <= gap_pkg::DIR_XP;
                    r_cur <= r_goal;
                    r_n   <= '0;
                end
                gap_pkg::ST_NBR: begin
                    if (nb_ok) r_open[nb_i] <= 1'b1;
                    r_dir  <= r_dir + 2'd1;
                    r_cnt  <= '0;
                    r_have <= 1'b0;
                end
                gap_pkg::ST_TRACE: begin
                    r_n <= r_n + (IW+1)'(1);
                end
                gap_pkg::ST_TSTEP: begin
                    r_cur <= par_i;
                end
                gap_pkg::ST_EMIT: begin
                    r_valid <= 1'b1;
                    r_res <= '{8'(XW'(em_c % IW'(gap_pkg::GRID_W))) - 8'(gap_pkg::CX_OFF),
                               8'(YW'(em_c / IW'(gap_pkg::GRID_W))) - 8'(gap_pkg::CY_OFF),
                               1'b1, r_n == (IW+1)'(1)};
                    r_n <= r_n - (IW+1)'(1);
                end
                gap_pkg::ST_FAIL: begin
                    r_valid <= 1'b1;
                    r_res   <= '{r_req.cell_x, r_req.cell_y, 1'b0, 1'b1};
                end
                default: ;
            endcase
        end
    end

    assign o_busy  = r_state != gap_pkg::ST_IDLE;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    a_start_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == gap_pkg::ST_CLEAR |=> r_open[r_start] && r_closed == '0)
        else $error("start not opened");
    a_emit_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == gap_pkg::ST_EMIT |=> o_valid && o_res.found)
        else $error("path cell missing");
    a_fail_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == gap_pkg::ST_FAIL |=> o_valid && !o_res.found && o_res.last)
        else $error("bad fail result");
endmodule

// File: tb/grid_astar_checker.sv
`timescale 1ns / 1ps

module grid_astar_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  gap_pkg::t_in  i_req,
    input  logic          i_busy,
    input  logic          i_valid,
    input  gap_pkg::t_out i_res,
    output int            o_fail_count,
    output int            o_pending
);

    bit            walk_map [gap_pkg::NCELLS];
    bit            occ_map  [gap_pkg::NCELLS];
    gap_pkg::t_out route_q  [$];

    function automatic bit in_grid(int cx, int cy, output int idx);
        int x;
        int y;
        x = gap_pkg::CX_OFF + cx;
        y = gap_pkg::CY_OFF + cy;
        idx = 0;
        if (x < 0 || y < 0 || x >= gap_pkg::GRID_W || y >= gap_pkg::GRID_H) return 0;
        idx = y * gap_pkg::GRID_W + x;
        return 1;
    endfunction

    function automatic void push_cell(int x, int y, bit fnd, bit lst);
        gap_pkg::t_out o;
        o.path_x = x[7:0];
        o.path_y = y[7:0];
        o.found  = fnd;
        o.last   = lst;
        route_q = {route_q, o};
    endfunction

    // a* over the shadow maps; returns 0 when the open set runs dry
    function automatic bit plan_route(int s, int g);
        int  g_cost [gap_pkg::NCELLS];
        int  from   [gap_pkg::NCELLS];
        bit  open_c [gap_pkg::NCELLS];
        bit  done_c [gap_pkg::NCELLS];
        int  trail  [$];
        int  dx [4];
        int  dy [4];
        int  best, bestf, f, nx, ny, ni, cur, gx, gy;
        dx = '{1, -1, 0, 0};
        dy = '{0, 0, 1, -1};
        gx = g % gap_pkg::GRID_W;
        gy = g / gap_pkg::GRID_W;
        foreach (open_c[i]) begin
            open_c[i] = 0;
            done_c[i] = 0;
            g_cost[i] = 0;
            from[i] = 0;
        end
        open_c[s] = 1;
        for (int it = 0; it < gap_pkg::NCELLS; it++) begin
            best = -1;
            bestf = 32'h7fff;
            for (int i = 0; i < gap_pkg::NCELLS; i++) begin
                if (open_c[i] && !done_c[i]) begin
                    f = g_cost[i]
                        + ((i % gap_pkg::GRID_W > gx) ? i % gap_pkg::GRID_W - gx
                                                      : gx - i % gap_pkg::GRID_W)
                        + ((i / gap_pkg::GRID_W > gy) ? i / gap_pkg::GRID_W - gy
                                                      : gy - i / gap_pkg::GRID_W);
                    if (f < bestf) begin
                        bestf = f;
                        best = i;
                    end
                end
            end
            if (best < 0) return 0;
            open_c[best] = 0;
            done_c[best] = 1;
            if (best == g) begin
                cur = g;
                while (cur != s && trail.size() < gap_pkg::NCELLS - 1) begin
                    trail.push_front(cur);
                    cur = (cur % gap_pkg::GRID_W - dx[from[cur]])
                        + (cur / gap_pkg::GRID_W - dy[from[cur]]) * gap_pkg::GRID_W;
                    if (cur < 0 || cur >= gap_pkg::NCELLS) return 0;
                end
                trail.push_front(s);
                foreach (trail[k])
                    push_cell(trail[k] % gap_pkg::GRID_W - gap_pkg::CX_OFF,
                              trail[k] / gap_pkg::GRID_W - gap_pkg::CY_OFF, 1,
                              k == trail.size() - 1);
                return 1;
            end
            for (int d = 0; d < 4; d++) begin
                nx = best % gap_pkg::GRID_W + dx[d];
                ny = best / gap_pkg::GRID_W + dy[d];
                if (nx < 0 || ny < 0 || nx >= gap_pkg::GRID_W || ny >= gap_pkg::GRID_H) continue;
                ni = ny * gap_pkg::GRID_W + nx;
                if (!walk_map[ni]) continue;
                if (occ_map[ni] && ni != g) continue;
                if (done_c[ni]) continue;
                if (!open_c[ni] || g_cost[best] + 1 < g_cost[ni]) begin
                    g_cost[ni] = (g_cost[best] + 1) & 8'h7f;
                    from[ni] = d;
                    open_c[ni] = 1;
                end
            end
        end
        return 0;
    endfunction

    function automatic void predict_request(gap_pkg::t_in r);
        int cx, cy, s, g;
        bit s_ok, g_ok;
        cx = int'(r.cell_x);
        cy = int'(r.cell_y);
        s_ok = in_grid(cx, cy, s);
        g_ok = in_grid(int'(r.goal_x), int'(r.goal_y), g);
        case (gap_pkg::t_req'(r.req_type))
            gap_pkg::REQ_FIND: begin
                if (!s_ok || !g_ok || !walk_map[s] || !walk_map[g] || !plan_route(s, g))
                    push_cell(cx, cy, 0, 1);
            end
            gap_pkg::REQ_SET_WALK: begin
                if (s_ok) walk_map[s] = r.walk_value;
                push_cell(cx, cy, 0, 1);
            end
            gap_pkg::REQ_OCCUPY: begin
                if (s_ok) occ_map[s] = 1;
                push_cell(cx, cy, 0, 1);
            end
            default: begin
                if (s_ok) occ_map[s] = 0;
                push_cell(cx, cy, 0, 1);
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        gap_pkg::t_out e;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            foreach (walk_map[i]) begin
                walk_map[i] = 1;
                occ_map[i] = 0;
            end
            route_q.delete();
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            if (i_valid) begin
                if (route_q.size() == 0) begin
                    $error("unexpected result x=%0d y=%0d", i_res.path_x, i_res.path_y);
                    errs = errs + 1;
                end else begin
                    e = route_q.pop_front();
                    if (e.path_x !== i_res.path_x) begin
                        $error("path_x expected %0d got %0d", e.path_x, i_res.path_x);
                        errs = errs + 1;
                    end
                    if (e.path_y !== i_res.path_y) begin
                        $error("path_y expected %0d got %0d", e.path_y, i_res.path_y);
                        errs = errs + 1;
                    end
                    if (e.found !== i_res.found) begin
                        $error("found expected %0b got %0b", e.found, i_res.found);
                        errs = errs + 1;
                    end
                    if (e.last !== i_res.last) begin
                        $error("last expected %0b got %0b", e.last, i_res.last);
                        errs = errs + 1;
                    end
                end
            end
            if (i_start && !i_busy) predict_request(i_req);
            o_fail_count <= o_fail_count + errs;
            o_pending <= route_q.size();
        end
    end

endmodule

// File: tb/tb_grid_astar_pathfinder.sv
`timescale 1ns / 1ps

module tb_grid_astar_pathfinder;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_start;
    gap_pkg::t_in  i_req;
    logic          o_busy;
    logic          o_valid;
    gap_pkg::t_out o_res;
    int            fail_count;
    int            pending;
    bit            allow_gaps;

    grid_astar_pathfinder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_req   (i_req),
        .o_busy  (o_busy),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    grid_astar_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .i_req        (i_req),
        .i_busy       (o_busy),
        .i_valid      (o_valid),
        .i_res        (o_res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #25_000_000;
        $display("grid_astar_pathfinder test failed");
        $finish;
    end

    task automatic send(gap_pkg::t_req kind, int cx, int cy, bit wv, int gx, int gy);
        gap_pkg::t_in r;
        bit           ok;
        r.req_type = kind;
        r.cell_x = cx[7:0];
        r.cell_y = cy[7:0];
        r.walk_value = wv;
        r.goal_x = gx[7:0];
        r.goal_y = gy[7:0];
        i_start <= 1;
        i_req <= r;
        do begin
            @(negedge i_clk);
            ok = !o_busy;
            @(posedge i_clk);
        end while (!ok);
        if (allow_gaps && $urandom_range(99) < 22) begin
            i_start <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    function automatic int near_coord();
        if ($urandom_range(9) == 0) return int'($signed(8'($urandom)));
        return $urandom_range(8) - 4;
    endfunction

    initial begin
        gap_pkg::t_req kind;
        i_start = 0;
        i_req = '0;
        i_rst_n = 0;
        allow_gaps = 1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // extremes, outside targets, acks of every kind
        send(gap_pkg::REQ_SET_WALK, -128, 127, 1, 127, -128);
        send(gap_pkg::REQ_OCCUPY, 127, -128, 0, -128, 127);
        send(gap_pkg::REQ_RELEASE, -1, -1, 1, -1, -1);
        send(gap_pkg::REQ_FIND, -128, 0, 0, 0, 0);
        send(gap_pkg::REQ_FIND, 0, 0, 1, 127, 127);
        send(gap_pkg::REQ_FIND, 1, 1, 0, 1, 1);
        send(gap_pkg::REQ_FIND, -3, -3, 0, 4, 4);
        // blocked endpoints
        send(gap_pkg::REQ_SET_WALK, 2, 2, 0, 0, 0);
        send(gap_pkg::REQ_FIND, 2, 2, 0, 0, 0);
        send(gap_pkg::REQ_FIND, 0, 0, 0, 2, 2);
        send(gap_pkg::REQ_SET_WALK, 2, 2, 1, 0, 0);
        // no path: wall in the corner
        send(gap_pkg::REQ_SET_WALK, -2, -3, 0, 0, 0);
        send(gap_pkg::REQ_SET_WALK, -3, -2, 0, 0, 0);
        send(gap_pkg::REQ_FIND, -3, -3, 0, 4, 4);
        send(gap_pkg::REQ_SET_WALK, -2, -3, 1, 0, 0);
        send(gap_pkg::REQ_SET_WALK, -3, -2, 1, 0, 0);
        // occupied detour, occupied goal, occupied start
        send(gap_pkg::REQ_OCCUPY, 1, 0, 0, 0, 0);
        send(gap_pkg::REQ_FIND, 0, 0, 0, 3, 0);
        send(gap_pkg::REQ_FIND, 0, 0, 0, 1, 0);
        send(gap_pkg::REQ_OCCUPY, 0, 0, 0, 0, 0);
        send(gap_pkg::REQ_FIND, 0, 0, 0, -3, 2);
        send(gap_pkg::REQ_RELEASE, 1, 0, 0, 0, 0);
        send(gap_pkg::REQ_RELEASE, 0, 0, 0, 0, 0);
        send(gap_pkg::REQ_FIND, 4, -3, 1, -3, 4);

        for (int n = 0; n < 116; n++) begin
            allow_gaps = !(n >= 50 && n < 90);
            case ($urandom_range(9))
                0, 1, 2: kind = gap_pkg::REQ_SET_WALK;
                3:       kind = gap_pkg::REQ_OCCUPY;
                4:       kind = gap_pkg::REQ_RELEASE;
                default: kind = gap_pkg::REQ_FIND;
            endcase
            send(kind, near_coord(), near_coord(), $urandom_range(9) < 7,
                 near_coord(), near_coord());
        end
        i_start <= 0;

        do @(negedge i_clk); while (o_busy || pending != 0);
        repeat (300) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("grid_astar_pathfinder test passed");
        else
            $display("grid_astar_pathfinder test failed");
        $finish;
    end

endmodule
